[rtl/core/ssd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the segment table of the six-digit scan display.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int VALUE_W  = 22;
	localparam int REST_W   = 17;
	localparam int Q5_W     = 6;
	localparam int CODE_W   = 8;
	localparam int DIGITS   = 6;
	localparam int POS_W    = 3;
	localparam int ROUNDS_W = 16;
	localparam int TICKS_W  = 20;

	// Reciprocals: m = ceil(2^s / d), exact over the operand range used.
	localparam logic [VALUE_W-1:0] SECTION_DIV = 22'd100000;
	localparam logic [22:0] M_SECTION = 23'd5497559;
	localparam int          S_SECTION = 39;
	localparam logic [17:0] M_DIV10    = 18'd209716;
	localparam int          S_DIV10    = 21;
	localparam logic [17:0] M_DIV100   = 18'd167773;
	localparam int          S_DIV100   = 24;
	localparam logic [17:0] M_DIV1000  = 18'd134218;
	localparam int          S_DIV1000  = 27;
	localparam logic [17:0] M_DIV10000 = 18'd214749;
	localparam int          S_DIV10000 = 31;

	localparam logic [CODE_W-1:0] SEG_BLANK = 8'h00;
	localparam logic [CODE_W-1:0] SEG_MINUS = 8'h40;
	localparam logic [CODE_W-1:0] SEG_ONE   = 8'h06;
	localparam logic [CODE_W-1:0] POINT_BIT = 8'h80;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic REG_ROUNDS = 1'b0;
	localparam logic REG_TICKS  = 1'b1;

	localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 16'd150;
	localparam logic [TICKS_W-1:0]  TICKS_RESET  = 20'd1;

	typedef logic [DIGITS-1:0][CODE_W-1:0] codes_t;

	typedef struct packed {
		logic   cmd;
		codes_t codes;
	} pipe_item_t;

	typedef struct packed {
		logic [ROUNDS_W-1:0] refresh_rounds;
		logic [TICKS_W-1:0]  ticks_per_digit;
	} cfg_t;

	// Hex digit to segments a..g; anything above fifteen is blank.
	function automatic logic [CODE_W-1:0] seg_of(input logic [Q5_W-1:0] d);
		logic [CODE_W-1:0] s;
		case (d)
			6'd0:    s = 8'h3f;
			6'd1:    s = 8'h06;
			6'd2:    s = 8'h5b;
			6'd3:    s = 8'h4f;
			6'd4:    s = 8'h66;
			6'd5:    s = 8'h6d;
			6'd6:    s = 8'h7d;
			6'd7:    s = 8'h07;
			6'd8:    s = 8'h7f;
			6'd9:    s = 8'h6f;
			6'd10:   s = 8'h77;
			6'd11:   s = 8'h7c;
			6'd12:   s = 8'h39;
			6'd13:   s = 8'h5e;
			6'd14:   s = 8'h79;
			6'd15:   s = 8'h71;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[rtl/core/seven_segment_scan_display.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_scan_display
// Six-digit multiplexed seven-segment display scanner with stream ports.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one result per item. Each item passes
// through the digit-split pipeline: input register, section quotient,
// remainder, decimal quotients, segment codes, then the scan state and result
// register. The whole pipeline holds while a result waits on m_tready, so
// nothing is dropped under back-pressure. A write item
// (tuser = 0) stores a new value and restarts the scan; a tick item
// (tuser = 1) advances it. Registers at APB byte address 0 (refresh_rounds)
// and 4 (ticks_per_digit) should only be written while no item is in flight.
module seven_segment_scan_display (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// item in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [21:0] value, [23:22] zero
	input  wire logic        s_tuser,   // [0] command
	// result out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // [5:0] grid_lines, [13:6] segment_lines,
	                                    // [14] busy_res, [15] zero
);
	import ssd_pkg::*;

	cfg_t               cfg;
	pipe_item_t         item_s5;
	logic               valid_s5;
	logic               adv;
	logic [DIGITS-1:0]  grid;
	logic [CODE_W-1:0]  segs;
	logic               busy;

	// pipeline moves whenever the result register is free or being drained
	assign adv      = ~m_tvalid | m_tready;
	assign s_tready = adv;

	ssd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssd_digit_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser),
		.in_value  (s_tdata[VALUE_W-1:0]),
		.out_valid (valid_s5),
		.out_item  (item_s5)
	);

	ssd_scan_ctrl u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s5),
		.in_item   (item_s5),
		.cfg       (cfg),
		.out_valid (m_tvalid),
		.grid      (grid),
		.segs      (segs),
		.busy      (busy)
	);

	assign m_tdata = {1'b0, busy, segs, grid};

endmodule
`default_nettype wire

[rtl/core/ssd_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_cfg_regs
// APB register file: refresh round count and ticks per digit.
// ----------------------------------------------------------------------------
module ssd_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ssd_pkg::cfg_t     cfg
);
	import ssd_pkg::*;

	logic                wr_en;
	logic [ROUNDS_W-1:0] rounds_q;
	logic [TICKS_W-1:0]  ticks_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// paddr[2] selects the register; the byte offset bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q <= ROUNDS_RESET;
			ticks_q  <= TICKS_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ROUNDS: rounds_q <= pwdata[ROUNDS_W-1:0];
				REG_TICKS:  ticks_q  <= pwdata[TICKS_W-1:0];
				default:    rounds_q <= rounds_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROUNDS: prdata = {16'd0, rounds_q};
			REG_TICKS:  prdata = {12'd0, ticks_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg.refresh_rounds  = rounds_q;
	assign cfg.ticks_per_digit = ticks_q;

endmodule
`default_nettype wire

[rtl/core/ssd_digit_split.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_digit_split
// Input register and pipeline that turns a value into six segment codes.
// Ticks ride along so item order is kept.
// ----------------------------------------------------------------------------
module ssd_digit_split (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic                         in_cmd,
	input  wire logic [ssd_pkg::VALUE_W-1:0]  in_value,
	output logic                              out_valid,
	output ssd_pkg::pipe_item_t               out_item
);
	import ssd_pkg::*;

	logic [4:0] vld_q;

	// s1: input register
	logic               cmd_s1;
	logic [VALUE_W-1:0] value_s1;
	// s2: section quotient
	logic               cmd_s2;
	logic [VALUE_W-1:0] value_s2;
	logic [Q5_W-1:0]    q5_s2;
	// s3: remainder below one section
	logic               cmd_s3;
	logic [REST_W-1:0]  rest_s3;
	logic [CODE_W-1:0]  code5_s3;
	// s4: decimal quotients of the remainder
	logic               cmd_s4;
	logic [REST_W-1:0]  rest_s4;
	logic [CODE_W-1:0]  code5_s4;
	logic [13:0]        q10_s4;
	logic [9:0]         q100_s4;
	logic [6:0]         q1000_s4;
	logic [3:0]         q10000_s4;
	// s5: segment codes
	logic               cmd_s5;
	codes_t             codes_s5;

	logic [44:0]        prod5;
	logic [VALUE_W-1:0] sect_sub;
	logic [VALUE_W-1:0] rest_full;
	logic [34:0]        p10, p100, p1000, p10000;
	logic [REST_W-1:0]  units, tens, hunds, thous;
	logic [CODE_W-1:0]  sign_code;
	codes_t             codes_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], in_valid};
		end
	end

	assign prod5     = 45'(value_s1) * 45'(M_SECTION);
	assign sect_sub  = VALUE_W'(q5_s2) * SECTION_DIV;
	assign rest_full = value_s2 - sect_sub;

	assign p10    = 35'(rest_s3) * 35'(M_DIV10);
	assign p100   = 35'(rest_s3) * 35'(M_DIV100);
	assign p1000  = 35'(rest_s3) * 35'(M_DIV1000);
	assign p10000 = 35'(rest_s3) * 35'(M_DIV10000);

	// each digit is a quotient less ten times the next quotient up
	assign units = rest_s4 - REST_W'(q10_s4) * 17'd10;
	assign tens  = REST_W'(q10_s4) - REST_W'(q100_s4) * 17'd10;
	assign hunds = REST_W'(q100_s4) - REST_W'(q1000_s4) * 17'd10;
	assign thous = REST_W'(q1000_s4) - REST_W'(q10000_s4) * 17'd10;

	always_comb begin
		if (q10000_s4 > 4'd1) begin
			sign_code = SEG_MINUS;
		end else if (q10000_s4 == 4'd1) begin
			sign_code = SEG_ONE;
		end else begin
			sign_code = SEG_BLANK;
		end
		codes_n[0] = seg_of({2'b00, units[3:0]});
		codes_n[1] = seg_of({2'b00, tens[3:0]});
		codes_n[2] = seg_of({2'b00, hunds[3:0]}) | POINT_BIT;
		codes_n[3] = seg_of({2'b00, thous[3:0]});
		codes_n[4] = sign_code;
		codes_n[5] = code5_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1    <= in_cmd;
			value_s1  <= in_value;

			cmd_s2    <= cmd_s1;
			value_s2  <= value_s1;
			q5_s2     <= prod5[S_SECTION +: Q5_W];
			// note: prod5 is formed from the s1 register
			cmd_s3    <= cmd_s2;
			rest_s3   <= rest_full[REST_W-1:0];
			code5_s3  <= seg_of(q5_s2);

			cmd_s4    <= cmd_s3;
			rest_s4   <= rest_s3;
			code5_s4  <= code5_s3;
			q10_s4    <= p10[S_DIV10 +: 14];
			q100_s4   <= p100[S_DIV100 +: 10];
			q1000_s4  <= p1000[S_DIV1000 +: 7];
			q10000_s4 <= p10000[S_DIV10000 +: 4];

			cmd_s5    <= cmd_s4;
			codes_s5  <= codes_n;
		end
	end

	assign out_valid      = vld_q[4];
	assign out_item.cmd   = cmd_s5;
	assign out_item.codes = codes_s5;

endmodule
`default_nettype wire

[rtl/core/ssd_scan_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_scan_ctrl
// Scan state (codes, slot, tick and round counters) and the result register.
// ----------------------------------------------------------------------------
module ssd_scan_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire ssd_pkg::pipe_item_t           in_item,
	input  wire ssd_pkg::cfg_t                 cfg,
	output logic                               out_valid,
	output logic [ssd_pkg::DIGITS-1:0]         grid,
	output logic [ssd_pkg::CODE_W-1:0]         segs,
	output logic                               busy
);
	import ssd_pkg::*;

	localparam int DIGITS_LINES_L = DIGITS;

	codes_t              codes_q, codes_n;
	logic [POS_W-1:0]    pos_q, pos_n;
	logic [TICKS_W-1:0]  tick_q, tick_n, tick_inc;
	logic [ROUNDS_W-1:0] round_q, round_n, round_inc;
	logic                active_q, active_n;
	logic                upd;

	logic                          valid_q;
	logic [DIGITS_LINES_L-1:0]     grid_q, grid_n;
	logic [CODE_W-1:0]             segs_q, segs_n;

	assign upd       = en & in_valid;
	assign tick_inc  = tick_q + TICKS_W'(1);
	assign round_inc = round_q + ROUNDS_W'(1);

	always_comb begin
		codes_n  = codes_q;
		pos_n    = pos_q;
		tick_n   = tick_q;
		round_n  = round_q;
		active_n = active_q;
		if (in_item.cmd == CMD_WRITE) begin
			codes_n  = in_item.codes;
			pos_n    = '0;
			tick_n   = '0;
			round_n  = '0;
			active_n = 1'b1;
		end else if (active_q) begin
			tick_n = tick_inc;
			// a zero register behaves as one through these compares
			if (tick_inc >= cfg.ticks_per_digit) begin
				tick_n = '0;
				if (pos_q == POS_W'(DIGITS - 1)) begin
					pos_n   = '0;
					round_n = round_inc;
					if (round_inc >= cfg.refresh_rounds) begin
						active_n = 1'b0;
						round_n  = '0;
					end
				end else begin
					pos_n = pos_q + POS_W'(1);
				end
			end
		end

		if (active_n) begin
			grid_n = ~(DIGITS_LINES_L'(1 << (DIGITS - 1)) >> pos_n);
			segs_n = codes_n[pos_n];
		end else begin
			grid_n = '0;
			segs_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q  <= '0;
			pos_q    <= '0;
			tick_q   <= '0;
			round_q  <= '0;
			active_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en) begin
				valid_q <= in_valid;
			end
			if (upd) begin
				codes_q  <= codes_n;
				pos_q    <= pos_n;
				tick_q   <= tick_n;
				round_q  <= round_n;
				active_q <= active_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			grid_q <= grid_n;
			segs_q <= segs_n;
		end
	end

	assign out_valid = valid_q;
	assign grid      = grid_q;
	assign segs      = segs_q;
	assign busy      = active_q;

endmodule
`default_nettype wire
